// File: rtl/core/ftc_pkg.sv
// Shared types, codes and arithmetic helpers for the Frenet-to-Cartesian converter.
// Used by the controller, the datapath and the top level; depends on nothing else.
package ftc_pkg;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_ZERO_SEG = 2'd2;

    localparam int UNIT_FRAC_BITS = 30;
    localparam int SQRT_STEPS     = 32;
    localparam int DIV_STEPS      = 31;

    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_SEARCH    = 5'd1;
    localparam logic [4:0] OP_RD_PREV   = 5'd2;
    localparam logic [4:0] OP_RD_NEXT   = 5'd3;
    localparam logic [4:0] OP_DIFF      = 5'd4;
    localparam logic [4:0] OP_ABS       = 5'd5;
    localparam logic [4:0] OP_SQ_A      = 5'd6;
    localparam logic [4:0] OP_SQ_B      = 5'd7;
    localparam logic [4:0] OP_SQ_SUM    = 5'd8;
    localparam logic [4:0] OP_SQRT      = 5'd9;
    localparam logic [4:0] OP_DIV_INIT  = 5'd10;
    localparam logic [4:0] OP_DIV       = 5'd11;
    localparam logic [4:0] OP_SIGN      = 5'd12;
    localparam logic [4:0] OP_MUL1      = 5'd13;
    localparam logic [4:0] OP_MUL2      = 5'd14;
    localparam logic [4:0] OP_MUL3      = 5'd15;
    localparam logic [4:0] OP_MUL4      = 5'd16;
    localparam logic [4:0] OP_PSUM      = 5'd17;
    localparam logic [4:0] OP_ROUND     = 5'd18;
    localparam logic [4:0] OP_RES_LOAD  = 5'd19;
    localparam logic [4:0] OP_RES_EMPTY = 5'd20;
    localparam logic [4:0] OP_RES_ZERO  = 5'd21;
    localparam logic [4:0] OP_RES_OK    = 5'd22;

    typedef struct packed {
        logic       accept;
        logic [4:0] op;
    } ftc_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic search_done;
        logic seg_zero;
        logic sqrt_last;
        logic len_zero;
        logic div_last;
    } ftc_stat_t;

    // Divide by 2^30 and round to nearest, ties away from zero.
    function automatic logic signed [33:0] round_unit(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? (64'd0 - v) : v;
        r   = (mag + (64'd1 << (UNIT_FRAC_BITS - 1))) >> UNIT_FRAC_BITS;
        return v[63] ? (34'sd0 - $signed(r[33:0])) : $signed(r[33:0]);
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] base,
                                                   input logic signed [33:0] ofs);
        logic signed [34:0] sum;
        sum = 35'(base) + 35'(ofs);
        if (sum > 35'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (sum < -35'sd2147483648)
            return 32'sh80000000;
        else
            return sum[31:0];
    endfunction

endpackage

// File: rtl/core/frenet_to_cartesian_convert_core.sv
// Top level of the Frenet-to-Cartesian converter: waypoint table plus query engine.
// Depends on ftc_pkg, ftc_ctrl and ftc_dp.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------------
//  request   | start, busy           | req_type, entry_index, entry_x/y/s, query_s/d
//  result    | done (1-cycle strobe) | out_x, out_y, status
//  config    | cfg_valid, cfg_ready  | cfg_data (waypoint_count)
//
// The search of a query reads one of the n table entries in use per cycle; after it,
// a bit-serial square root and two serial dividers running in parallel dominate a query.
// Reset clears control state and sets waypoint_count to 1; table contents are
// undefined until loaded. Results cannot be stalled; cfg_ready is always high.
module frenet_to_cartesian_convert_core
#(
    parameter int MAX_WAYPOINTS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [7:0]         entry_index,
    input  logic signed [31:0] entry_x,
    input  logic signed [31:0] entry_y,
    input  logic [30:0]        entry_s,
    input  logic [30:0]        query_s,
    input  logic signed [31:0] query_d,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         cfg_data
);
    import ftc_pkg::*;

    ftc_cmd_t  cmd;
    ftc_stat_t stat;

    assign cfg_ready = 1'b1;

    ftc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    ftc_dp #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .entry_index (entry_index),
        .entry_x     (entry_x),
        .entry_y     (entry_y),
        .entry_s     (entry_s),
        .query_s     (query_s),
        .query_d     (query_d),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .out_x       (out_x),
        .out_y       (out_y),
        .status      (status),
        .done        (done)
    );

endmodule

// File: rtl/core/ftc_ctrl.sv
// Sequencing state machine of the Frenet-to-Cartesian converter.
// Depends on ftc_pkg; drives the datapath through command and status structs.
module ftc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              req_type,
    input  ftc_pkg::ftc_stat_t stat,
    output ftc_pkg::ftc_cmd_t  cmd,
    output logic              busy
);
    import ftc_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SEARCH    = 5'd1;
    localparam logic [4:0] S_RD_PREV   = 5'd2;
    localparam logic [4:0] S_RD_NEXT   = 5'd3;
    localparam logic [4:0] S_DIFF      = 5'd4;
    localparam logic [4:0] S_ABS       = 5'd5;
    localparam logic [4:0] S_SQ_A      = 5'd6;
    localparam logic [4:0] S_SQ_B      = 5'd7;
    localparam logic [4:0] S_SQ_SUM    = 5'd8;
    localparam logic [4:0] S_SQRT      = 5'd9;
    localparam logic [4:0] S_DIV_INIT  = 5'd10;
    localparam logic [4:0] S_DIV       = 5'd11;
    localparam logic [4:0] S_SIGN      = 5'd12;
    localparam logic [4:0] S_MUL1      = 5'd13;
    localparam logic [4:0] S_MUL2      = 5'd14;
    localparam logic [4:0] S_MUL3      = 5'd15;
    localparam logic [4:0] S_MUL4      = 5'd16;
    localparam logic [4:0] S_PSUM      = 5'd17;
    localparam logic [4:0] S_ROUND     = 5'd18;
    localparam logic [4:0] S_RES_LOAD  = 5'd19;
    localparam logic [4:0] S_RES_EMPTY = 5'd20;
    localparam logic [4:0] S_RES_ZERO  = 5'd21;
    localparam logic [4:0] S_RES_OK    = 5'd22;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_LOAD)
                        state_next = S_RES_LOAD;
                    else if (stat.count_zero)
                        state_next = S_RES_EMPTY;
                    else
                        state_next = S_SEARCH;
                end
            end
            S_SEARCH:   if (stat.search_done) state_next = S_RD_PREV;
            S_RD_PREV:  state_next = S_RD_NEXT;
            S_RD_NEXT:  state_next = S_DIFF;
            S_DIFF:     state_next = S_ABS;
            S_ABS:      state_next = stat.seg_zero ? S_RES_ZERO : S_SQ_A;
            S_SQ_A:     state_next = S_SQ_B;
            S_SQ_B:     state_next = S_SQ_SUM;
            S_SQ_SUM:   state_next = S_SQRT;
            S_SQRT:     if (stat.sqrt_last) state_next = S_DIV_INIT;
            S_DIV_INIT: state_next = stat.len_zero ? S_RES_ZERO : S_DIV;
            S_DIV:      if (stat.div_last) state_next = S_SIGN;
            S_SIGN:     state_next = S_MUL1;
            S_MUL1:     state_next = S_MUL2;
            S_MUL2:     state_next = S_MUL3;
            S_MUL3:     state_next = S_MUL4;
            S_MUL4:     state_next = S_PSUM;
            S_PSUM:     state_next = S_ROUND;
            S_ROUND:    state_next = S_RES_OK;
            S_RES_LOAD, S_RES_EMPTY, S_RES_ZERO, S_RES_OK: state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.accept = (state_reg == S_IDLE) && start;
        case (state_reg)
            S_SEARCH:    cmd.op = OP_SEARCH;
            S_RD_PREV:   cmd.op = OP_RD_PREV;
            S_RD_NEXT:   cmd.op = OP_RD_NEXT;
            S_DIFF:      cmd.op = OP_DIFF;
            S_ABS:       cmd.op = OP_ABS;
            S_SQ_A:      cmd.op = OP_SQ_A;
            S_SQ_B:      cmd.op = OP_SQ_B;
            S_SQ_SUM:    cmd.op = OP_SQ_SUM;
            S_SQRT:      cmd.op = OP_SQRT;
            S_DIV_INIT:  cmd.op = stat.len_zero ? OP_NONE : OP_DIV_INIT;
            S_DIV:       cmd.op = OP_DIV;
            S_SIGN:      cmd.op = OP_SIGN;
            S_MUL1:      cmd.op = OP_MUL1;
            S_MUL2:      cmd.op = OP_MUL2;
            S_MUL3:      cmd.op = OP_MUL3;
            S_MUL4:      cmd.op = OP_MUL4;
            S_PSUM:      cmd.op = OP_PSUM;
            S_ROUND:     cmd.op = OP_ROUND;
            S_RES_LOAD:  cmd.op = OP_RES_LOAD;
            S_RES_EMPTY: cmd.op = OP_RES_EMPTY;
            S_RES_ZERO:  cmd.op = OP_RES_ZERO;
            S_RES_OK:    cmd.op = OP_RES_OK;
            default:     cmd.op = OP_NONE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: rtl/core/ftc_dp.sv
// Datapath of the Frenet-to-Cartesian converter: waypoint memories, search,
// bit-serial square root, two serial dividers and a shared multiplier. Depends on ftc_pkg.
module ftc_dp
#(
    parameter int MAX_WAYPOINTS = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ftc_pkg::ftc_cmd_t   cmd,
    output ftc_pkg::ftc_stat_t  stat,
    input  logic                req_type,
    input  logic [7:0]          entry_index,
    input  logic signed [31:0]  entry_x,
    input  logic signed [31:0]  entry_y,
    input  logic [30:0]         entry_s,
    input  logic [30:0]         query_s,
    input  logic signed [31:0]  query_d,
    input  logic                cfg_write,
    input  logic [8:0]          cfg_data,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic [1:0]          status,
    output logic                done
);
    import ftc_pkg::*;

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

    logic signed [31:0] mem_x [MAX_WAYPOINTS];
    logic signed [31:0] mem_y [MAX_WAYPOINTS];
    logic [30:0]        mem_s [MAX_WAYPOINTS];

    logic [8:0]  count_reg;
    logic [AW-1:0] last_reg;
    logic [30:0] qs_reg;
    logic signed [31:0] qd_reg;

    logic [AW-1:0] rd_addr;
    logic signed [31:0] rd_x_reg, rd_y_reg;
    logic [30:0] rd_s_reg;

    logic [AW-1:0] srch_idx_reg, cmp_idx_reg, prev_reg, next_idx;
    logic cmp_valid_reg;
    logic above;

    logic signed [31:0] x_prev_reg, y_prev_reg;
    logic [30:0] s_prev_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic dx_neg_reg, dy_neg_reg;
    logic [30:0] ax_reg, ay_reg;
    logic [32:0] mag_x, mag_y;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg, acc_reg, px_reg, py_reg;

    logic [63:0] sq_rem_reg, sq_root_reg, sq_bit_reg, sq_try;
    logic [5:0]  sq_cnt_reg;
    logic [31:0] len;

    logic [31:0] dc_rem_reg, ds_rem_reg;
    logic [30:0] dc_low_reg, ds_low_reg, dc_q_reg, ds_q_reg;
    logic [4:0]  div_cnt_reg;
    logic [61:0] num_c, num_s;
    logic [32:0] dc_try, ds_try;

    logic signed [31:0] cs_reg, sn_reg, seg_reg;
    logic signed [33:0] rx_reg, ry_reg;

    logic signed [31:0] out_x_reg, out_y_reg;
    logic [1:0] status_reg;
    logic done_reg;

    logic [31:0] n_full;

    assign n_full = (32'(count_reg) > MAX_WAYPOINTS) ? 32'(MAX_WAYPOINTS) : 32'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 9'd1;
        else if (cfg_write)
            count_reg <= cfg_data;
    end

    // Table write happens in the cycle the load transaction is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (req_type == REQ_LOAD) && (32'(entry_index) < MAX_WAYPOINTS))
        begin
            mem_x[AW'(entry_index)] <= entry_x;
            mem_y[AW'(entry_index)] <= entry_y;
            mem_s[AW'(entry_index)] <= entry_s;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
        rd_s_reg <= mem_s[rd_addr];
    end

    assign next_idx = (prev_reg == last_reg) ? '0 : prev_reg + 1'b1;

    always_comb
    begin
        case (cmd.op)
            OP_SEARCH:  rd_addr = srch_idx_reg;
            OP_RD_PREV: rd_addr = prev_reg;
            OP_RD_NEXT: rd_addr = next_idx;
            default:    rd_addr = srch_idx_reg;
        endcase
    end

    // One entry is compared per cycle, in the cycle after its read address is presented.
    assign above = (qs_reg > rd_s_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_SEARCH)
        begin
            cmp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            qs_reg       <= query_s;
            qd_reg       <= query_d;
            last_reg     <= AW'(n_full - 32'd1);
            srch_idx_reg <= '0;
            prev_reg     <= '0;
        end
        else if (cmd.op == OP_SEARCH)
        begin
            cmp_idx_reg <= srch_idx_reg;
            if (srch_idx_reg != last_reg)
                srch_idx_reg <= srch_idx_reg + 1'b1;
            if (cmp_valid_reg && above)
                prev_reg <= cmp_idx_reg;
        end
    end

    assign mag_x = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign mag_y = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_RD_NEXT:
            begin
                x_prev_reg <= rd_x_reg;
                y_prev_reg <= rd_y_reg;
                s_prev_reg <= rd_s_reg;
            end
            OP_DIFF:
            begin
                dx_reg <= 33'(rd_x_reg) - 33'(x_prev_reg);
                dy_reg <= 33'(rd_y_reg) - 33'(y_prev_reg);
            end
            OP_ABS:
            begin
                dx_neg_reg <= dx_reg[32];
                dy_neg_reg <= dy_reg[32];
                // Both magnitudes are halved when either would overflow 31 bits.
                if ((mag_x[32:31] != 2'b00) || (mag_y[32:31] != 2'b00))
                begin
                    ax_reg <= mag_x[31:1];
                    ay_reg <= mag_y[31:1];
                end
                else
                begin
                    ax_reg <= mag_x[30:0];
                    ay_reg <= mag_y[30:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            OP_SQ_A: begin mul_a = {1'b0, ax_reg}; mul_b = {1'b0, ax_reg}; end
            OP_SQ_B: begin mul_a = {1'b0, ay_reg}; mul_b = {1'b0, ay_reg}; end
            OP_MUL1: begin mul_a = seg_reg;        mul_b = cs_reg;         end
            OP_MUL2: begin mul_a = qd_reg;         mul_b = sn_reg;         end
            OP_MUL3: begin mul_a = seg_reg;        mul_b = sn_reg;         end
            OP_MUL4: begin mul_a = qd_reg;         mul_b = cs_reg;         end
            default: begin mul_a = seg_reg;        mul_b = cs_reg;         end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_SQ_B: acc_reg <= prod_reg;
            OP_MUL2: acc_reg <= prod_reg;
            OP_MUL3: px_reg  <= acc_reg + prod_reg;
            OP_MUL4: acc_reg <= prod_reg;
            OP_PSUM: py_reg  <= acc_reg - prod_reg;
            OP_ROUND:
            begin
                rx_reg <= round_unit(px_reg);
                ry_reg <= round_unit(py_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Integer square root, one result bit per cycle.
    assign sq_try = sq_root_reg + sq_bit_reg;
    assign len    = sq_root_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_SQ_SUM)
        begin
            sq_rem_reg  <= acc_reg + prod_reg;
            sq_root_reg <= '0;
            sq_bit_reg  <= 64'd1 << 62;
            sq_cnt_reg  <= '0;
        end
        else if (cmd.op == OP_SQRT)
        begin
            if (sq_rem_reg >= sq_try)
            begin
                sq_rem_reg  <= sq_rem_reg - sq_try;
                sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_root_reg <= sq_root_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
        end
    end

    // The quotient fits 31 bits, so the top half of the numerator seeds the remainder.
    assign num_c  = {1'b0, ax_reg, 30'd0} + 62'(len[31:1]);
    assign num_s  = {1'b0, ay_reg, 30'd0} + 62'(len[31:1]);
    assign dc_try = {dc_rem_reg, dc_low_reg[30]};
    assign ds_try = {ds_rem_reg, ds_low_reg[30]};

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIV_INIT)
        begin
            dc_rem_reg  <= {1'b0, num_c[61:31]};
            ds_rem_reg  <= {1'b0, num_s[61:31]};
            dc_low_reg  <= num_c[30:0];
            ds_low_reg  <= num_s[30:0];
            dc_q_reg    <= '0;
            ds_q_reg    <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.op == OP_DIV)
        begin
            if (dc_try >= {1'b0, len})
            begin
                dc_rem_reg <= 32'(dc_try - {1'b0, len});
                dc_q_reg   <= {dc_q_reg[29:0], 1'b1};
            end
            else
            begin
                dc_rem_reg <= dc_try[31:0];
                dc_q_reg   <= {dc_q_reg[29:0], 1'b0};
            end
            if (ds_try >= {1'b0, len})
            begin
                ds_rem_reg <= 32'(ds_try - {1'b0, len});
                ds_q_reg   <= {ds_q_reg[29:0], 1'b1};
            end
            else
            begin
                ds_rem_reg <= ds_try[31:0];
                ds_q_reg   <= {ds_q_reg[29:0], 1'b0};
            end
            dc_low_reg  <= dc_low_reg << 1;
            ds_low_reg  <= ds_low_reg << 1;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        else if (cmd.op == OP_SIGN)
        begin
            cs_reg  <= dx_neg_reg ? (32'sd0 - $signed({1'b0, dc_q_reg})) : $signed({1'b0, dc_q_reg});
            sn_reg  <= dy_neg_reg ? (32'sd0 - $signed({1'b0, ds_q_reg})) : $signed({1'b0, ds_q_reg});
            seg_reg <= $signed({1'b0, qs_reg}) - $signed({1'b0, s_prev_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_RES_LOAD:  begin out_x_reg <= '0; out_y_reg <= '0; status_reg <= STATUS_OK;       end
            OP_RES_EMPTY: begin out_x_reg <= '0; out_y_reg <= '0; status_reg <= STATUS_EMPTY;    end
            OP_RES_ZERO:  begin out_x_reg <= '0; out_y_reg <= '0; status_reg <= STATUS_ZERO_SEG; end
            OP_RES_OK:
            begin
                out_x_reg  <= add_sat(x_prev_reg, rx_reg);
                out_y_reg  <= add_sat(y_prev_reg, ry_reg);
                status_reg <= STATUS_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (cmd.op == OP_RES_LOAD) || (cmd.op == OP_RES_EMPTY) ||
                        (cmd.op == OP_RES_ZERO) || (cmd.op == OP_RES_OK);
    end

    assign stat.count_zero  = (count_reg == 9'd0);
    assign stat.search_done = cmp_valid_reg && (!above || (cmp_idx_reg == last_reg));
    assign stat.seg_zero    = (dx_reg == 33'sd0) && (dy_reg == 33'sd0);
    assign stat.sqrt_last   = (sq_cnt_reg == 6'(SQRT_STEPS - 1));
    assign stat.len_zero    = (len == 32'd0);
    assign stat.div_last    = (div_cnt_reg == 5'(DIV_STEPS - 1));

    assign out_x  = out_x_reg;
    assign out_y  = out_y_reg;
    assign status = status_reg;
    assign done   = done_reg;

endmodule

// File: rtl/core/ftc_checker.sv
// Port-level checks for the Frenet-to-Cartesian converter, bound to the top level.
// Depends on ftc_pkg for the status codes and on the top-level ports.
module ftc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_y,
    input logic [1:0]         status
);
    import ftc_pkg::*;

    // An accepted transaction must raise busy; the block then stays busy until its result.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result strobes in a row");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STATUS_OK || status == STATUS_EMPTY || status == STATUS_ZERO_SEG))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STATUS_OK) |-> (out_x == 32'sd0) && (out_y == 32'sd0))
        else $error("error result carries nonzero coordinates");

endmodule

bind frenet_to_cartesian_convert_core ftc_checker u_ftc_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .out_x  (out_x),
    .out_y  (out_y),
    .status (status)
);
